[hw/rtl/mdr_pkg.sv]
// Shared types and constants for the multiply/divide register unit.
package mdr_pkg;

  // Register offsets within the page
  localparam logic [4:0] OFF_MULTIPLICAND = 5'h02;
  localparam logic [4:0] OFF_MULTIPLIER   = 5'h03;
  localparam logic [4:0] OFF_DIVIDEND_LO  = 5'h04;
  localparam logic [4:0] OFF_DIVIDEND_HI  = 5'h05;
  localparam logic [4:0] OFF_DIVISOR      = 5'h06;
  localparam logic [4:0] OFF_QUOT_LO      = 5'h14;
  localparam logic [4:0] OFF_QUOT_HI      = 5'h15;
  localparam logic [4:0] OFF_PR_LO        = 5'h16;
  localparam logic [4:0] OFF_PR_HI        = 5'h17;

  // Access kind carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Iteration counts of the shared unit
  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [15:0] DIV_ZERO_QUOT = 16'hFFFF;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } mdr_op_t;

  // Start request from the register front end to the arithmetic unit
  typedef struct packed {
    logic       start;
    mdr_op_t    op;
    logic [7:0] operand;   // new multiplier or divisor byte
  } mdr_cmd_t;

  // Completion report from the arithmetic unit
  typedef struct packed {
    logic        done;
    mdr_op_t     op;
    logic [15:0] quot;
    logic [15:0] pr;
  } mdr_res_t;

endpackage

[hw/rtl/mdr_arith.sv]
// Iterative shift-add multiplier and restoring divider around one shared adder.
module mdr_arith (
  input  logic             clk,
  input  logic             rst,
  input  mdr_pkg::mdr_cmd_t cmd,
  input  logic [7:0]       multiplicand,
  input  logic [15:0]      dividend,
  output mdr_pkg::mdr_res_t res
);

  logic                      busy;
  logic                      done;
  logic [mdr_pkg::CNT_W-1:0] count;
  mdr_pkg::mdr_op_t          op;
  logic                      div_zero;
  logic [7:0]                acc;      // product high byte / partial remainder
  logic [15:0]               work;     // multiplier bits / dividend-quotient
  logic [7:0]                opnd;     // multiplicand or divisor

  logic [8:0] add_a;
  logic [8:0] add_b;
  logic       add_sub;
  logic [9:0] add_sum;

  // Shared adder: operand selection by operation
  always_comb begin
    if (op == mdr_pkg::OP_MUL) begin
      add_a   = {1'b0, acc};
      add_b   = work[0] ? {1'b0, opnd} : 9'd0;
      add_sub = 1'b0;
    end else begin
      add_a   = {acc, work[15]};
      add_b   = {1'b0, opnd};
      add_sub = 1'b1;
    end
    add_sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
              + {9'd0, add_sub};
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        if (cmd.op == mdr_pkg::OP_DIV && cmd.operand == 8'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: load on start, one step per cycle while busy
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op       <= cmd.op;
      opnd     <= (cmd.op == mdr_pkg::OP_MUL) ? multiplicand : cmd.operand;
      acc      <= 8'd0;
      div_zero <= (cmd.op == mdr_pkg::OP_DIV) && (cmd.operand == 8'd0);
      if (cmd.op == mdr_pkg::OP_MUL) begin
        work  <= {8'd0, cmd.operand};
        count <= mdr_pkg::CNT_W'(mdr_pkg::MUL_STEPS - 1);
      end else begin
        work  <= dividend;
        count <= mdr_pkg::CNT_W'(mdr_pkg::DIV_STEPS - 1);
      end
    end else if (busy) begin
      count <= count - 1'b1;
      if (op == mdr_pkg::OP_MUL) begin
        acc       <= add_sum[8:1];
        work[7:0] <= {add_sum[0], work[7:1]};
      end else begin
        // top bit set means the trial subtraction borrowed: keep the partial
        // remainder and shift in a zero quotient bit
        acc  <= add_sum[9] ? add_a[7:0] : add_sum[7:0];
        work <= {work[14:0], ~add_sum[9]};
      end
    end
  end

  // Result view
  always_comb begin
    res.done = done;
    res.op   = op;
    if (op == mdr_pkg::OP_MUL) begin
      res.quot = work;
      res.pr   = {acc, work[7:0]};
    end else if (div_zero) begin
      res.quot = mdr_pkg::DIV_ZERO_QUOT;
      res.pr   = work;
    end else begin
      res.quot = work;
      res.pr   = {8'd0, acc};
    end
  end

endmodule

[hw/rtl/mul_div_register_unit.sv]
// Top level: register page, access sequencer and read-data output register.
// A read transfer's byte is registered and appears on the master side the
// next cycle. A write of the multiplicand or a dividend byte does not hold
// s_tready low. A write of the multiplier runs the shift-add multiplier for
// 8 steps and holds s_tready low until the product is captured; a write of
// the divisor runs the restoring divider for 16 steps and holds s_tready
// low until the quotient and remainder are captured, or only until the
// zero-divisor result is captured. Both share one 9-bit adder and a counter.
// A new transfer is taken only when no read result is left waiting.
module mul_div_register_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] reg_index, [12:5] write_data, [15:13] zero
  input  logic        s_tuser,   // [0] func (0 write, 1 read)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] read_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [7:0]  multiplicand;
  logic [7:0]  multiplier;
  logic [15:0] dividend;
  logic [7:0]  divisor;
  logic [15:0] quotient;
  logic [15:0] product_or_remainder;

  logic [4:0] reg_index;
  logic [7:0] write_data;
  logic       accept;
  logic       wr;
  logic       rd;
  logic [7:0] rd_byte;

  mdr_pkg::mdr_cmd_t cmd;
  mdr_pkg::mdr_res_t res;

  assign reg_index  = s_tdata[4:0];
  assign write_data = s_tdata[12:5];
  assign s_tready   = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign wr         = accept && (s_tuser == mdr_pkg::FUNC_WRITE);
  assign rd         = accept && (s_tuser == mdr_pkg::FUNC_READ);

  // Start the shared unit on a multiplier or divisor write
  always_comb begin
    cmd.operand = write_data;
    cmd.start   = 1'b0;
    cmd.op      = mdr_pkg::OP_MUL;
    if (wr && reg_index == mdr_pkg::OFF_MULTIPLIER) begin
      cmd.start = 1'b1;
    end else if (wr && reg_index == mdr_pkg::OFF_DIVISOR) begin
      cmd.start = 1'b1;
      cmd.op    = mdr_pkg::OP_DIV;
    end
  end

  mdr_arith u_arith (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .multiplicand (multiplicand),
    .dividend     (dividend),
    .res          (res)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (res.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Register page writes and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplicand         <= 8'd0;
      multiplier           <= 8'd0;
      dividend             <= 16'd0;
      divisor              <= 8'd0;
      quotient             <= 16'd0;
      product_or_remainder <= 16'd0;
    end else begin
      if (wr) begin
        case (reg_index)
          mdr_pkg::OFF_MULTIPLICAND: multiplicand   <= write_data;
          mdr_pkg::OFF_MULTIPLIER:   multiplier     <= write_data;
          mdr_pkg::OFF_DIVIDEND_LO:  dividend[7:0]  <= write_data;
          mdr_pkg::OFF_DIVIDEND_HI:  dividend[15:8] <= write_data;
          mdr_pkg::OFF_DIVISOR:      divisor        <= write_data;
          default: ;
        endcase
      end
      if (state == ST_BUSY && res.done) begin
        product_or_remainder <= res.pr;
        if (res.op == mdr_pkg::OP_DIV) quotient <= res.quot;
      end
    end
  end

  // Read decode
  always_comb begin
    case (reg_index)
      mdr_pkg::OFF_QUOT_LO: rd_byte = quotient[7:0];
      mdr_pkg::OFF_QUOT_HI: rd_byte = quotient[15:8];
      mdr_pkg::OFF_PR_LO:   rd_byte = product_or_remainder[7:0];
      mdr_pkg::OFF_PR_HI:   rd_byte = product_or_remainder[15:8];
      default:              rd_byte = 8'd0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) m_tdata <= rd_byte;
  end

  // Operand copies kept for visibility of the page; divisor/multiplier unused by reads
  logic unused_regs;
  assign unused_regs = ^{multiplier, divisor};

endmodule

[hw/rtl/mdr_checker.sv]
// Port-level checker for the multiply/divide register unit, bound to the top level.
module mdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  logic acc_rd;
  logic acc_wr;
  logic rd_mapped;

  assign acc_rd    = s_tvalid && s_tready && (s_tuser == mdr_pkg::FUNC_READ);
  assign acc_wr    = s_tvalid && s_tready && (s_tuser == mdr_pkg::FUNC_WRITE);
  assign rd_mapped = (s_tdata[4:0] == mdr_pkg::OFF_QUOT_LO) ||
                     (s_tdata[4:0] == mdr_pkg::OFF_QUOT_HI) ||
                     (s_tdata[4:0] == mdr_pkg::OFF_PR_LO)   ||
                     (s_tdata[4:0] == mdr_pkg::OFF_PR_HI);

  // A read transfer always produces a result next cycle
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    acc_rd |=> m_tvalid)
    else $error("read transfer produced no result");

  // Unmapped reads return zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    acc_rd && !rd_mapped |=> m_tdata == 8'd0)
    else $error("unmapped read returned nonzero data");

  // Starting an arithmetic operation blocks the slave side
  a_op_busy: assert property (@(posedge clk) disable iff (rst)
    acc_wr && (s_tdata[4:0] == mdr_pkg::OFF_MULTIPLIER ||
               s_tdata[4:0] == mdr_pkg::OFF_DIVISOR) |=> !s_tready)
    else $error("slave ready while arithmetic unit runs");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind mul_div_register_unit mdr_checker u_mdr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
